[rtl/nfb_pkg.sv]
// shared types and constants of the notch filter biquad unit
`timescale 1ns / 1ps
package nfb_pkg;

  localparam int SampleW = 16;
  localparam int OutW    = 32;
  localparam int AW      = 40;
  localparam int A2W     = 48;
  localparam int TW      = 49;
  localparam int DenW    = 51;
  localparam int DivW    = 52;
  localparam int QW      = 36;
  localparam int MulW    = 48;
  localparam int ProdW   = 96;
  localparam int AccW    = 80;
  localparam int CntW    = 6;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_ANG_FREQ    = 2'd0;
  localparam reg_idx_t REG_SHARPNESS   = 2'd1;
  localparam reg_idx_t REG_SAMPLE_TIME = 2'd2;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic [31:0] ANG_FREQ_RST    = 32'd65536000;
  localparam logic [15:0] SHARPNESS_RST   = 16'd256;
  localparam logic [31:0] SAMPLE_TIME_RST = 32'd429497;

endpackage

[rtl/nfb_in_if.sv]
// input sample channel
`timescale 1ns / 1ps
interface nfb_in_if import nfb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [SampleW-1:0] sample_in;

  modport source(output valid, command, sample_in, input ready);
  modport sink(input valid, command, sample_in, output ready);
endinterface

[rtl/nfb_out_if.sv]
// filtered sample channel
`timescale 1ns / 1ps
interface nfb_out_if import nfb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample_out;
  logic                      saturated;

  modport source(output valid, sample_out, saturated, input ready);
  modport sink(input valid, sample_out, saturated, output ready);
endinterface

[rtl/nfb_mul.sv]
// shared byte-serial unsigned multiplier
`timescale 1ns / 1ps
module nfb_mul import nfb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MulW-1:0]  op_a,
  input  logic [MulW-1:0]  op_b,
  output logic [ProdW-1:0] prod,
  output logic             done
);

  localparam int Steps = MulW / 8;

  logic [MulW-1:0]  mc_r;
  logic [MulW-1:0]  mp_r;
  logic [ProdW-1:0] acc_r;
  logic [2:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [MulW+7:0]  pp;

  assign pp   = mc_r * mp_r[MulW-1 -: 8];
  assign prod = acc_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'(Steps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= op_a;
      mp_r  <= op_b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= {acc_r[ProdW-9:0], 8'b0} + ProdW'(pp);
      mp_r  <= {mp_r[MulW-9:0], 8'b0};
    end
  end

endmodule

[rtl/nfb_div.sv]
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module nfb_div import nfb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DenW-1:0] rem_init,
  input  logic [DivW-1:0] dvd,
  input  logic [DenW-1:0] den,
  input  logic [CntW-1:0] nbits,
  output logic [DivW-1:0] quo,
  output logic            done
);

  logic [DenW-1:0] rem_r;
  logic [DivW-1:0] dvd_r;
  logic [DivW-1:0] quo_r;
  logic [DenW-1:0] den_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DenW:0]   rs;
  logic [DenW:0]   diff;
  logic            ge;

  assign rs   = {rem_r, dvd_r[DivW-1]};
  assign ge   = rs >= {1'b0, den_r};
  assign diff = rs - {1'b0, den_r};
  assign quo  = quo_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CntW'(1);
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      dvd_r <= dvd;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DenW-1:0] : rs[DenW-1:0];
      quo_r <= {quo_r[DivW-2:0], ge};
      dvd_r <= {dvd_r[DivW-2:0], 1'b0};
    end
  end

endmodule

[rtl/notch_filter_biquad_unit.sv]
// notch filter biquad unit: top level with register port and sequencer
//
// usage
//   in_ch carries one transaction per sample: command selects filtering of
//   sample_in or a clear of the filter history. out_ch returns exactly one
//   transaction for each input: the rounded, saturated sample and its flag.
//   the cfg_ port writes ang_freq (0x0), sharpness (0x4), sample_time (0x8);
//   write only while no sample is in flight.
// sequence
//   a filtered sample passes through the shared byte-serial multiplier
//   (five products) and bit-serial divider (one 49-bit quotient, three
//   36-bit quotients) before out_ch valid; a clear goes straight to output.
//   in_ch.ready is high only while the sequencer is idle, so a new
//   transaction is accepted only once the last has left the sequencer.
// reset
//   registers take their default values and the history is zero.
// stall
//   the result sits in an output register; a new sample is accepted while
//   it waits, and the sequencer holds its next result until the slot frees.
`timescale 1ns / 1ps
module notch_filter_biquad_unit import nfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  nfb_in_if.sink      in_ch,
  nfb_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_A, ST_MUL_A2, ST_DIV_T, ST_DEN,
    ST_DIV0, ST_DIV1, ST_DIV2, ST_MAC0, ST_MAC1, ST_MAC2, ST_OUT
  } state_t;

  state_t state_r;

  logic [31:0] ang_freq_r;
  logic [15:0] sharp_r;
  logic [31:0] stime_r;

  logic signed [SampleW-1:0] prev_in1_r, prev_in2_r, x_r;
  logic signed [OutW-1:0]    prev_out1_r, prev_out2_r;

  logic [AW-1:0]   a_r;
  logic [A2W-1:0]  a2_r;
  logic [TW-1:0]   t_r;
  logic [DenW-1:0] den_r;
  logic [QW-1:0]   cmag_r [3];
  logic [2:0]      csgn_r;
  logic signed [AccW-1:0] acc_r;
  logic            clear_r;

  logic                      out_valid_r;
  logic signed [SampleW-1:0] out_sample_r;
  logic                      out_sat_r;

  logic mul_start_r, div_start_r;
  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] mul_prod;
  logic             mul_done;
  logic [DenW-1:0]  div_rem, div_den;
  logic [DivW-1:0]  div_dvd, div_quo;
  logic [CntW-1:0]  div_nbits;
  logic             div_done;

  // ---------------- register port
  logic     cfg_wr;
  reg_idx_t cfg_idx;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_freq_r <= ANG_FREQ_RST;
      sharp_r    <= SHARPNESS_RST;
      stime_r    <= SAMPLE_TIME_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ANG_FREQ:    ang_freq_r <= cfg_pwdata;
        REG_SHARPNESS:   sharp_r    <= cfg_pwdata[15:0];
        REG_SAMPLE_TIME: stime_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ANG_FREQ:    cfg_prdata = ang_freq_r;
      REG_SHARPNESS:   cfg_prdata = {16'b0, sharp_r};
      REG_SAMPLE_TIME: cfg_prdata = stime_r;
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------- operand selection
  logic [15:0]              qv;
  logic signed [SampleW:0]  xsum;
  logic signed [OutW+1:0]   sig;
  logic [OutW+1:0]          sig_mag;
  logic [1:0]               tap;
  logic signed [DivW-1:0]   num;
  logic [DivW-1:0]          num_mag;
  logic                     term_neg;
  logic [AccW-1:0]          term;

  assign qv   = (sharp_r == 16'd0) ? 16'd1 : sharp_r;
  assign xsum = (SampleW+1)'(x_r) + (SampleW+1)'(prev_in2_r);

  always_comb begin
    case (state_r)
      ST_MAC1, ST_DIV1: tap = 2'd1;
      ST_MAC2, ST_DIV2: tap = 2'd2;
      default:          tap = 2'd0;
    endcase
  end

  always_comb begin
    case (tap)
      2'd1:    sig = (OutW+2)'($signed({prev_in1_r, 16'b0})) - (OutW+2)'(prev_out1_r);
      2'd2:    sig = (OutW+2)'(prev_out2_r);
      default: sig = (OutW+2)'($signed({xsum, 16'b0}));
    endcase
  end
  assign sig_mag = sig[OutW+1] ? (OutW+2)'(-sig) : sig;

  always_comb begin
    case (tap)
      2'd1:    num = $signed(DivW'({a2_r, 1'b0})) - $signed(DivW'(64'd1 << 35));
      2'd2:    num = $signed(DivW'(64'd1 << 34)) + $signed(DivW'(a2_r))
                     - $signed(DivW'(t_r));
      default: num = $signed(DivW'(64'd1 << 34)) + $signed(DivW'(a2_r));
    endcase
  end
  assign num_mag = num[DivW-1] ? DivW'(-num) : num;

  always_comb begin
    case (state_r)
      ST_MUL_A: begin
        mul_a = MulW'(ang_freq_r);
        mul_b = MulW'(stime_r);
      end
      ST_MUL_A2: begin
        mul_a = MulW'(a_r);
        mul_b = MulW'(a_r);
      end
      default: begin
        mul_a = MulW'(cmag_r[tap]);
        mul_b = MulW'(sig_mag);
      end
    endcase
  end

  always_comb begin
    if (state_r == ST_DIV_T) begin
      div_rem   = '0;
      div_dvd   = {a_r, 12'b0};
      div_den   = DenW'(qv);
      div_nbits = CntW'(TW);
    end else begin
      div_rem   = DenW'(num_mag >> 4);
      div_dvd   = {num_mag[3:0], 48'b0};
      div_den   = den_r;
      div_nbits = CntW'(QW);
    end
  end

  assign term_neg = csgn_r[tap] ^ sig[OutW+1] ^ (tap == 2'd2);
  assign term     = term_neg ? AccW'(-mul_prod[AccW-1:0]) : mul_prod[AccW-1:0];

  // ---------------- output rounding
  logic signed [A2W-1:0]  y48;
  logic signed [OutW-1:0] y32;
  logic signed [OutW:0]   ysum;
  logic signed [SampleW:0] yi;
  logic signed [SampleW-1:0] ys;
  logic                   ysat;
  logic                   out_free;

  assign y48 = acc_r[AccW-1:OutW];
  always_comb begin
    if (!y48[A2W-1] && (y48[A2W-2:OutW-1] != '0))
      y32 = {1'b0, {(OutW-1){1'b1}}};
    else if (y48[A2W-1] && (y48[A2W-2:OutW-1] != '1))
      y32 = {1'b1, {(OutW-1){1'b0}}};
    else
      y32 = y48[OutW-1:0];
  end
  assign ysum = (OutW+1)'(y32) + (OutW+1)'(32768);
  assign yi   = ysum[OutW:16];
  always_comb begin
    ysat = 1'b0;
    ys   = yi[SampleW-1:0];
    if (yi[SampleW] != yi[SampleW-1]) begin
      ysat = 1'b1;
      ys   = yi[SampleW] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  // ---------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      clear_r     <= 1'b0;
      prev_in1_r  <= '0;
      prev_in2_r  <= '0;
      prev_out1_r <= '0;
      prev_out2_r <= '0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      if (out_valid_r && out_ch.ready && state_r != ST_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            x_r     <= in_ch.sample_in;
            clear_r <= (in_ch.command == CMD_CLEAR);
            if (in_ch.command == CMD_CLEAR) begin
              state_r <= ST_OUT;
            end else begin
              state_r     <= ST_MUL_A;
              mul_start_r <= 1'b1;
            end
          end
        end
        ST_MUL_A: begin
          if (mul_done) begin
            a_r         <= (mul_prod[63:56] != 8'd0) ? '1 : mul_prod[55:16];
            state_r     <= ST_MUL_A2;
            mul_start_r <= 1'b1;
          end
        end
        ST_MUL_A2: begin
          if (mul_done) begin
            a2_r        <= mul_prod[79:32];
            state_r     <= ST_DIV_T;
            div_start_r <= 1'b1;
          end
        end
        ST_DIV_T: begin
          if (div_done) begin
            t_r     <= div_quo[TW-1:0];
            state_r <= ST_DEN;
          end
        end
        ST_DEN: begin
          den_r       <= DenW'(64'd1 << 34) + DenW'(t_r) + DenW'(a2_r);
          state_r     <= ST_DIV0;
          div_start_r <= 1'b1;
        end
        ST_DIV0, ST_DIV1, ST_DIV2: begin
          if (div_done) begin
            cmag_r[tap] <= div_quo[QW-1:0];
            csgn_r[tap] <= num[DivW-1];
            if (state_r == ST_DIV2) begin
              state_r     <= ST_MAC0;
              acc_r       <= AccW'(64'd1 << 31);
              mul_start_r <= 1'b1;
            end else begin
              state_r     <= (state_r == ST_DIV0) ? ST_DIV1 : ST_DIV2;
              div_start_r <= 1'b1;
            end
          end
        end
        ST_MAC0, ST_MAC1, ST_MAC2: begin
          if (mul_done) begin
            acc_r <= acc_r + $signed(term);
            if (state_r == ST_MAC2) begin
              state_r <= ST_OUT;
            end else begin
              state_r     <= (state_r == ST_MAC0) ? ST_MAC1 : ST_MAC2;
              mul_start_r <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
            if (clear_r) begin
              out_sample_r <= '0;
              out_sat_r    <= 1'b0;
              prev_in1_r   <= '0;
              prev_in2_r   <= '0;
              prev_out1_r  <= '0;
              prev_out2_r  <= '0;
            end else begin
              out_sample_r <= ys;
              out_sat_r    <= ysat;
              prev_in2_r   <= prev_in1_r;
              prev_in1_r   <= x_r;
              prev_out2_r  <= prev_out1_r;
              prev_out1_r  <= y32;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.saturated  = out_sat_r;

  nfb_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  nfb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .rem_init (div_rem),
    .dvd      (div_dvd),
    .den      (div_den),
    .nbits    (div_nbits),
    .quo      (div_quo),
    .done     (div_done)
  );

  // ---------------- checks
  a_one_unit_start: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_start_r && div_start_r))
    else $error("multiplier and divider started together");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && clear_r && out_free) |=>
      (prev_in1_r == '0 && prev_in2_r == '0 && prev_out1_r == '0 && prev_out2_r == '0))
    else $error("history not cleared");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      (out_sample_r == {1'b1, {(SampleW-1){1'b0}}} ||
       out_sample_r == {1'b0, {(SampleW-1){1'b1}}}))
    else $error("saturation flag without clipped value");

  a_coef_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (div_done && (state_r == ST_DIV0 || state_r == ST_DIV1 || state_r == ST_DIV2)) |->
      (div_quo[DivW-1:QW] == '0))
    else $error("coefficient quotient overflow");

endmodule

[test/notch_filter_biquad_unit_tb.sv]
// self-checking testbench of the notch filter biquad unit
`timescale 1ns / 1ps
module notch_filter_biquad_unit_tb;
  import nfb_pkg::*;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic                      saturated;
  } filt_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  nfb_in_if  in_ch();
  nfb_out_if out_ch();

  notch_filter_biquad_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [31:0] w_reg = ANG_FREQ_RST;
  logic [15:0] q_reg = SHARPNESS_RST;
  logic [31:0] ts_reg = SAMPLE_TIME_RST;
  logic signed [63:0] hist_x1 = 0, hist_x2 = 0, hist_y1 = 0, hist_y2 = 0;
  filt_res_t expected_q[$];
  int errors = 0;
  bit idle_on = 1'b1;
  bit sink_idle_on = 1'b1;

  function automatic logic signed [63:0] frac_quot(logic signed [63:0] num,
                                                   logic [63:0] den);
    logic [127:0] m;
    logic [127:0] q;
    m = (num < 0) ? -num : num;
    q = (m << 32) / den;
    return (num < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic filt_res_t filter_step(logic cmd, logic signed [15:0] x_in);
    filt_res_t r;
    logic [63:0] a, a2, t, qv, den, four;
    logic signed [63:0] b0, b1, c2, x, y, yi;
    logic signed [127:0] acc, top;
    r = '0;
    if (cmd == CMD_CLEAR) begin
      hist_x1 = 0; hist_x2 = 0; hist_y1 = 0; hist_y2 = 0;
      return r;
    end
    x = x_in;
    a = (64'(w_reg) * 64'(ts_reg)) >> 16;
    if (a > (64'd256 << 32) - 1) a = (64'd256 << 32) - 1;
    a2 = (128'(a) * 128'(a)) >> 32;
    qv = (q_reg == 0) ? 64'd1 : 64'(q_reg);
    t = (a << 9) / qv;
    four = 64'd4 << 32;
    den = four + t + a2;
    b0 = frac_quot($signed(four + a2), den);
    b1 = frac_quot($signed(2 * a2) - $signed(2 * four), den);
    c2 = frac_quot($signed(four + a2 - t), den);
    acc = 128'(b0) * 128'((x + hist_x2) * 65536)
        + 128'(b1) * 128'(hist_x1 * 65536 - hist_y1)
        - 128'(c2) * 128'(hist_y2) + (128'sd1 <<< 31);
    top = acc >>> 32;
    if (top > 128'sd2147483647) y = 64'sd2147483647;
    else if (top < -128'sd2147483648) y = -64'sd2147483648;
    else y = 64'(top);
    hist_x2 = hist_x1; hist_x1 = x; hist_y2 = hist_y1; hist_y1 = y;
    yi = (y + 32768) >>> 16;
    if (yi > 32767) begin yi = 32767; r.saturated = 1'b1; end
    if (yi < -32768) begin yi = -32768; r.saturated = 1'b1; end
    r.sample_out = yi[15:0];
    return r;
  endfunction

  task automatic send_sample(logic cmd, logic signed [15:0] x);
    if (idle_on && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while (idle_on && $urandom_range(99) < 25) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.sample_in <= x;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(filter_step(cmd, x));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_ANG_FREQ:    w_reg = val;
      REG_SHARPNESS:   q_reg = val[15:0];
      REG_SAMPLE_TIME: ts_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic set_filter(logic [31:0] w, logic [15:0] q, logic [31:0] ts);
    drain_results();
    write_reg(REG_ANG_FREQ, w);
    write_reg(REG_SHARPNESS, q);
    write_reg(REG_SAMPLE_TIME, ts);
  endtask

  task automatic test_directed();
    send_sample(CMD_FILTER, 16'sd32767);
    send_sample(CMD_FILTER, -16'sd32768);
    send_sample(CMD_FILTER, 16'sd0);
    send_sample(CMD_FILTER, 16'sd32767);
    send_sample(CMD_CLEAR, 16'sd1234);
    send_sample(CMD_FILTER, -16'sd1);
    send_sample(CMD_FILTER, 16'sd1);
    set_filter(32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFFF);
    repeat (4) send_sample(CMD_FILTER, 16'sd32767);
    repeat (4) send_sample(CMD_FILTER, -16'sd32768);
    send_sample(CMD_CLEAR, -16'sd1);
    set_filter(32'd0, 16'hFFFF, 32'd0);
    send_sample(CMD_FILTER, 16'sh5A5A);
    send_sample(CMD_FILTER, -16'sh5A5B);
    set_filter(32'd1 << 30, 16'd1, 32'd1 << 20);
    repeat (4) send_sample(CMD_FILTER, 16'sd32767);
    send_sample(CMD_FILTER, -16'sd32768);
  endtask

  task automatic test_random_settings();
    logic [31:0] w, ts;
    logic [15:0] q;
    for (int ph = 0; ph < 10; ph++) begin
      w = $urandom;
      ts = $urandom >> $urandom_range(31);
      q = 16'($urandom_range(65535));
      set_filter(w, q, ts);
      idle_on = (ph != 4);
      sink_idle_on = (ph != 4);
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(99) < 4) send_sample(CMD_CLEAR, 16'($urandom));
        else send_sample(CMD_FILTER, 16'($urandom));
        if (i == 30 && ph == 2) begin
          in_ch.valid <= 1'b0;
          do @(negedge clk); while (expected_q.size() != 0);
        end
      end
    end
    idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // result checker
  always @(posedge clk) begin
    filt_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: sample_out %0d", out_ch.sample_out);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.sample_out !== e.sample_out) begin
          $error("sample_out expected %0d actual %0d", e.sample_out, out_ch.sample_out);
          errors++;
        end
        if (out_ch.saturated !== e.saturated) begin
          $error("saturated expected %0b actual %0b", e.saturated, out_ch.saturated);
          errors++;
        end
      end
    end
  end

  always @(negedge clk)
    out_ch.ready <= !(sink_idle_on && $urandom_range(99) < 25);

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_FILTER;
    in_ch.sample_in = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_settings();
    drain_results();
    if (errors == 0 && expected_q.size() == 0)
      $display("notch_filter_biquad_unit_tb: clean");
    else
      $display("notch_filter_biquad_unit_tb: errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("notch_filter_biquad_unit_tb: errors");
    $finish;
  end
endmodule
